// ===== sv/tmf_pkg.sv =====
`timescale 1ns / 1ps

package tmf_pkg;

  localparam int unsigned WINDOW_DEF = 16;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned TRIM_W     = 8;
  localparam logic [TRIM_W-1:0] TRIM_MAX = 8'd128;

  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned PADDR_W    = 3;
  localparam logic REG_TRIM_IDX      = 1'b0;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_KEY,
    ST_KEY_WAIT,
    ST_SCAN,
    ST_LAST,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_DONE
  } tmf_state_e;

endpackage

// ===== sv/tmf_sample_if.sv =====
`timescale 1ns / 1ps

interface tmf_sample_if;
  logic            valid;
  logic            ready;
  tmf_pkg::sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// ===== sv/tmf_result_if.sv =====
`timescale 1ns / 1ps

interface tmf_result_if;
  logic             valid;
  logic             ready;
  tmf_pkg::sample_t smoothed;
  logic             passed_through;

  modport source (output valid, output smoothed, output passed_through, input ready);
  modport sink (input valid, input smoothed, input passed_through, output ready);
endinterface

// ===== sv/tmf_ram.sv =====
`timescale 1ns / 1ps

module tmf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/tmf_divider.sv =====
`timescale 1ns / 1ps

// Restoring divider of a signed dividend by a positive divisor, one quotient bit
// per cycle. The quotient is truncated toward zero.
module tmf_divider #(
  parameter int unsigned SUM_W = 21,
  parameter int unsigned DIV_W = 5
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [SUM_W-1:0] dividend_i,
  input  logic [DIV_W-1:0]        divisor_i,
  output logic                    done_o,
  output tmf_pkg::sample_t        quotient_o
);

  localparam int unsigned STEP_W = $clog2(SUM_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  div_q, div_d;
  logic              neg_q, neg_d;

  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              fits;
  logic [SUM_W-1:0]  quo_signed;

  always_comb begin
    trial  = {rem_q, quo_q[SUM_W-1]};
    diff   = trial - {1'b0, div_q};
    fits   = trial >= {1'b0, div_q};
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(SUM_W);
      quo_d  = dividend_i[SUM_W-1] ? SUM_W'(-dividend_i) : SUM_W'(dividend_i);
      rem_d  = '0;
      div_d  = divisor_i;
      neg_d  = dividend_i[SUM_W-1];
    end else if (busy_q) begin
      quo_d  = {quo_q[SUM_W-2:0], fits};
      rem_d  = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      step_d = step_q - 1'b1;
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
    neg_q  <= neg_d;
  end

  assign quo_signed = neg_q ? (~quo_q + 1'b1) : quo_q;
  assign quotient_o = quo_signed[tmf_pkg::SAMPLE_W-1:0];
  assign done_o     = done_q;

endmodule

// ===== sv/trimmed_mean_window_filter.sv =====
`timescale 1ns / 1ps

// Channel   Modport  Payload                          Transaction when
// in_i      sink     sample (16b signed)              in_i.valid && in_i.ready
// out_o     source   smoothed (16b), passed_through   out_o.valid && out_o.ready
// apb       slave    trim_fraction at byte address 0  psel && penable && pwrite
//
// Each stored sample is ranked against all others by one comparator that reads the
// window memory one entry per cycle; the serial divider then divides the sum. Reset
// clears the fill count, write pointer, trim register and output valid. A finished
// result waits in the output register while the next sample is accepted.
module trimmed_mean_window_filter #(
  parameter int unsigned WINDOW = tmf_pkg::WINDOW_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  tmf_sample_if.sink                       in_i,
  tmf_result_if.source                     out_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tmf_pkg::PADDR_W-1:0]      paddr,
  input  logic [tmf_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [tmf_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);

  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned IDX_W  = $clog2(WINDOW);
  localparam int unsigned SUM_W  = tmf_pkg::SAMPLE_W + $clog2(WINDOW) + 1;
  localparam int unsigned PROD_W = tmf_pkg::TRIM_W + CNT_W;

  tmf_pkg::tmf_state_e state_q, state_d;

  logic [IDX_W-1:0]          wp_q;
  logic [CNT_W-1:0]          fill_q;
  logic [tmf_pkg::TRIM_W-1:0] trim_q;
  logic                      out_vld_q;
  tmf_pkg::sample_t          out_smooth_q;
  logic                      out_pass_q;

  tmf_pkg::sample_t          sample_q;
  tmf_pkg::sample_t          key_q;
  tmf_pkg::sample_t          res_q;
  logic                      res_pass_q;
  logic [IDX_W-1:0]          i_q;
  logic [IDX_W-1:0]          j_q;
  logic [IDX_W-1:0]          cmp_idx_q;
  logic                      cmp_vld_q;
  logic [CNT_W-1:0]          rank_q;
  logic [CNT_W-1:0]          lo_q;
  logic [CNT_W-1:0]          hi_q;
  logic signed [SUM_W-1:0]   acc_q;

  logic                      in_take;
  logic                      out_take;
  logic                      cfg_write;
  logic                      out_load;
  logic [IDX_W-1:0]          ram_raddr;
  tmf_pkg::sample_t          ram_rdata;
  logic                      div_start;
  logic                      div_done;
  tmf_pkg::sample_t          div_quot;

  logic [tmf_pkg::TRIM_W-1:0] trim_sat;
  logic [PROD_W-1:0]         prod;
  logic [CNT_W-1:0]          discard;
  logic [CNT_W-1:0]          hi_calc;
  logic                      too_few;
  logic                      inc;
  logic [CNT_W-1:0]          rank_fin;
  logic                      in_range;
  logic                      last_j;
  logic                      last_i;

  // Window storage.
  tmf_ram #(
    .WIDTH (tmf_pkg::SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (in_take),
    .waddr_i (wp_q),
    .wdata_i (in_i.sample),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tmf_divider #(
    .SUM_W (SUM_W),
    .DIV_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_q),
    .divisor_i  (hi_q - lo_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Trim window bounds for the current fill count.
  always_comb begin
    trim_sat = (trim_q > tmf_pkg::TRIM_MAX) ? tmf_pkg::TRIM_MAX : trim_q;
    prod     = PROD_W'(trim_sat) * PROD_W'(fill_q);
    discard  = prod[PROD_W-1 -: CNT_W];
    hi_calc  = fill_q - CNT_W'(1) - discard;
    too_few  = (fill_q < CNT_W'(2)) ||
               (((CNT_W + 1)'(fill_q) - (CNT_W + 1)'(1)) <= {discard, 1'b0});
  end

  // Rank comparison: ties are ordered by window index.
  always_comb begin
    inc      = (ram_rdata < key_q) || ((ram_rdata == key_q) && (cmp_idx_q < i_q));
    rank_fin = rank_q + CNT_W'(inc);
    in_range = (rank_fin >= lo_q) && (rank_fin < hi_q);
    last_j   = CNT_W'(j_q) == fill_q - CNT_W'(1);
    last_i   = CNT_W'(i_q) == fill_q - CNT_W'(1);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tmf_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          state_d = tmf_pkg::ST_SETUP;
        end
      end
      tmf_pkg::ST_SETUP: begin
        state_d = too_few ? tmf_pkg::ST_DONE : tmf_pkg::ST_KEY;
      end
      tmf_pkg::ST_KEY:      state_d = tmf_pkg::ST_KEY_WAIT;
      tmf_pkg::ST_KEY_WAIT: state_d = tmf_pkg::ST_SCAN;
      tmf_pkg::ST_SCAN: begin
        if (last_j) begin
          state_d = tmf_pkg::ST_LAST;
        end
      end
      tmf_pkg::ST_LAST: begin
        state_d = last_i ? tmf_pkg::ST_DIV_START : tmf_pkg::ST_KEY;
      end
      tmf_pkg::ST_DIV_START: state_d = tmf_pkg::ST_DIV_WAIT;
      tmf_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_d = tmf_pkg::ST_DONE;
        end
      end
      tmf_pkg::ST_DONE: begin
        if (!out_vld_q || out_o.ready) begin
          state_d = tmf_pkg::ST_IDLE;
        end
      end
      default: state_d = tmf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready = 1'b0;
    ram_raddr  = j_q;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      tmf_pkg::ST_IDLE:      in_i.ready = 1'b1;
      tmf_pkg::ST_KEY:       ram_raddr  = i_q;
      tmf_pkg::ST_DIV_START: div_start  = 1'b1;
      tmf_pkg::ST_DONE:      out_load   = !out_vld_q || out_o.ready;
      default: begin
        ram_raddr = j_q;
      end
    endcase
  end

  assign in_take   = in_i.valid && in_i.ready;
  assign out_take  = out_o.valid && out_o.ready;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == tmf_pkg::REG_TRIM_IDX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tmf_pkg::ST_IDLE;
      wp_q      <= '0;
      fill_q    <= '0;
      trim_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_take) begin
        wp_q   <= (wp_q == IDX_W'(WINDOW - 1)) ? '0 : wp_q + 1'b1;
        fill_q <= (fill_q == CNT_W'(WINDOW)) ? fill_q : fill_q + 1'b1;
      end
      if (cfg_write) begin
        trim_q <= pwdata[tmf_pkg::TRIM_W-1:0];
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_take) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      sample_q <= in_i.sample;
    end
    case (state_q)
      tmf_pkg::ST_SETUP: begin
        lo_q       <= discard;
        hi_q       <= hi_calc;
        res_q      <= sample_q;
        res_pass_q <= 1'b1;
        i_q        <= '0;
        acc_q      <= '0;
        rank_q     <= '0;
      end
      tmf_pkg::ST_KEY_WAIT: begin
        key_q     <= ram_rdata;
        j_q       <= '0;
        cmp_vld_q <= 1'b0;
        rank_q    <= '0;
      end
      tmf_pkg::ST_SCAN: begin
        cmp_vld_q <= 1'b1;
        cmp_idx_q <= j_q;
        j_q       <= j_q + 1'b1;
        if (cmp_vld_q) begin
          rank_q <= rank_fin;
        end
      end
      tmf_pkg::ST_LAST: begin
        if (in_range) begin
          acc_q <= acc_q + SUM_W'(key_q);
        end
        i_q <= i_q + 1'b1;
      end
      tmf_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          res_q      <= div_quot;
          res_pass_q <= 1'b0;
        end
      end
      default: begin
        i_q <= i_q;
      end
    endcase
    if (out_load) begin
      out_smooth_q <= res_q;
      out_pass_q   <= res_pass_q;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.smoothed       = out_smooth_q;
  assign out_o.passed_through = out_pass_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == tmf_pkg::REG_TRIM_IDX) ?
                  tmf_pkg::APB_DATA_W'(trim_q) : '0;

  a_fill_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> fill_q != '0)
    else $error("fill count is zero after a sample transaction");

  a_div_only_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == tmf_pkg::ST_DIV_WAIT)
    else $error("divider finished outside of its wait state");

  a_rank_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tmf_pkg::ST_LAST |-> rank_fin < fill_q)
    else $error("sample rank exceeds fill count");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q) == tmf_pkg::ST_DONE)
    else $error("result presented without a finished computation");

endmodule

// ===== dv/trimmed_mean_window_filter_chk.sv =====
`timescale 1ns / 1ps

module trimmed_mean_window_filter_chk
  import tmf_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tmf_sample_if                 smp_ch,
  tmf_result_if                 res_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic                  pready,
  output int                    fail_count,
  output int                    pending,
  output int                    results_checked,
  output int                    passthru_seen
);

  typedef struct packed {
    sample_t smoothed;
    logic    passed_through;
  } filt_result_t;

  sample_t           window_q [WINDOW];
  int unsigned       wr_slot;
  int unsigned       fill;
  logic [TRIM_W-1:0] trim_reg;
  filt_result_t      expected_q [$];

  initial begin
    fail_count      = 0;
    pending         = 0;
    results_checked = 0;
    passthru_seen   = 0;
    wr_slot         = 0;
    fill            = 0;
    trim_reg        = '0;
  end

  task automatic report_mismatch(input string what);
    if (fail_count < 25) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    fail_count++;
  endtask

  // Stores the sample, then averages the sorted window with the low and high
  // ends trimmed; too few samples left means the sample itself is passed on.
  function automatic filt_result_t push_and_average(input sample_t s);
    int           vals [WINDOW];
    int           key;
    int           j;
    int           total;
    int           lo;
    int           hi;
    int unsigned  trim;
    filt_result_t r;
    window_q[wr_slot] = s;
    wr_slot = (wr_slot + 1) % WINDOW;
    if (fill < WINDOW) begin
      fill++;
    end
    r.smoothed       = s;
    r.passed_through = 1'b1;
    if (fill < 2) begin
      return r;
    end
    for (int i = 0; i < fill; i++) begin
      vals[i] = window_q[i];
    end
    for (int i = 1; i < fill; i++) begin
      key = vals[i];
      j   = i;
      while (j > 0 && vals[j-1] > key) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = key;
    end
    trim = (trim_reg > TRIM_MAX) ? TRIM_MAX : trim_reg;
    lo   = int'((trim * fill) >> 8);
    hi   = int'(fill) - 1 - lo;
    if (hi - lo < 1) begin
      return r;
    end
    total = 0;
    for (int i = lo; i < hi; i++) begin
      total += vals[i];
    end
    total            = total / (hi - lo);
    r.smoothed       = sample_t'(total);
    r.passed_through = 1'b0;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    filt_result_t want;
    if (!rst_ni) begin
      wr_slot  = 0;
      fill     = 0;
      trim_reg = '0;
      expected_q.delete();
      pending  = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result transaction with no sample outstanding");
        end else begin
          want = expected_q.pop_front();
          results_checked++;
          if (res_ch.passed_through === 1'b1) begin
            passthru_seen++;
          end
          if (res_ch.smoothed !== want.smoothed) begin
            report_mismatch($sformatf("smoothed got %0d expected %0d",
                                      res_ch.smoothed, want.smoothed));
          end
          if (res_ch.passed_through !== want.passed_through) begin
            report_mismatch($sformatf("passed_through got %b expected %b",
                                      res_ch.passed_through, want.passed_through));
          end
        end
      end
      if (psel && penable && pwrite && pready && (paddr >> 2) == REG_TRIM_IDX) begin
        trim_reg = pwdata[TRIM_W-1:0];
      end
      if (smp_ch.valid && smp_ch.ready) begin
        expected_q.push_back(push_and_average(smp_ch.sample));
      end
      pending = expected_q.size();
    end
  end

endmodule

// ===== dv/trimmed_mean_window_filter_tb.sv =====
`timescale 1ns / 1ps

module trimmed_mean_window_filter_tb;
  import tmf_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 5_000_000;
  localparam int unsigned HOLD_CYCLES  = 3000;
  localparam int unsigned DRAIN_CYCLES = 400;
  localparam int unsigned PHASES       = 12;
  localparam int unsigned PHASE_ITEMS  = 157;
  localparam int unsigned RAND_PHASE   = 9;
  localparam int unsigned PRESS_PHASE  = 4;
  localparam logic [PADDR_W-1:0] TRIM_ADDR     = {REG_TRIM_IDX, 2'b00};
  localparam logic [PADDR_W-1:0] UNMAPPED_ADDR = {~REG_TRIM_IDX, 2'b00};

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_W-1:0]    paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int          fail_count;
  int          pending;
  int          results_checked;
  int          passthru_seen;
  int unsigned cycle_cnt = 0;
  int unsigned items_sent = 0;
  int unsigned trims_written = 0;
  int unsigned src_gap_pct = 0;
  int unsigned snk_stall_pct = 0;
  logic        holding;
  event        hold_kick;

  tmf_sample_if smp_ch ();
  tmf_result_if res_ch ();

  trimmed_mean_window_filter uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (smp_ch),
    .out_o   (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  trimmed_mean_window_filter_chk chk_u (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .smp_ch          (smp_ch),
    .res_ch          (res_ch),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked),
    .passthru_seen   (passthru_seen)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("trimmed_mean_window_filter_tb: FAIL");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    res_ch.ready <= !holding && ($urandom_range(99) >= snk_stall_pct);
  end

  // The receiver holds off for a long stretch so the block fills and stalls its input.
  initial begin
    holding = 1'b0;
    forever begin
      @(hold_kick);
      holding = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      holding = 1'b0;
    end
  end

  task automatic offer_sample(input sample_t value);
    @(negedge clk_i);
    while ($urandom_range(99) < src_gap_pct) begin
      smp_ch.valid  <= 1'b0;
      smp_ch.sample <= sample_t'($urandom());
      @(negedge clk_i);
    end
    smp_ch.valid  <= 1'b1;
    smp_ch.sample <= value;
    do @(posedge clk_i); while (!smp_ch.ready);
    items_sent++;
  endtask

  task automatic drain;
    @(negedge clk_i);
    smp_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_trim(input logic [TRIM_W-1:0] trim);
    logic [APB_DATA_W-1:0] word;
    word              = $urandom();
    word[TRIM_W-1:0]  = trim;
    apb_write(TRIM_ADDR, word);
    trims_written++;
  endtask

  function automatic sample_t pick_sample(input sample_t prev);
    int unsigned mode;
    mode = $urandom_range(99);
    if (mode < 40) begin
      return sample_t'($urandom());
    end else if (mode < 55) begin
      case ($urandom_range(4))
        0:       return 16'sh8000;
        1:       return 16'sh7FFF;
        2:       return 16'sh0000;
        3:       return 16'shFFFF;
        default: return 16'sh0001;
      endcase
    end else if (mode < 80) begin
      return prev + sample_t'($urandom_range(6)) - 16'sh0003;
    end else if ($urandom_range(1) == 0) begin
      return 16'sh7F00 + sample_t'($urandom_range(255));
    end
    return 16'sh8000 + sample_t'($urandom_range(255));
  endfunction

  initial begin
    sample_t           directed_vals [20] = '{
      16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001,
      16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000,
      16'sh3039, 16'shCFC7, 16'sh0002, 16'shFFFE, 16'sh0064,
      16'shFF9C, 16'sh7FFF, 16'sh8000, 16'sh0007, 16'shFFF9
    };
    logic [TRIM_W-1:0] trim_plan [PHASES] = '{
      8'd0, 8'd1, 8'd16, 8'd128, 8'd40, 8'd255,
      8'd64, 8'd127, 8'd129, 8'd0, 8'd100, 8'd0
    };
    sample_t           last_sample;
    logic [TRIM_W-1:0] trim;

    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    smp_ch.valid  = 1'b0;
    smp_ch.sample = '0;
    res_ch.ready  = 1'b0;
    last_sample   = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_trim(8'd0);
    foreach (directed_vals[i]) begin
      offer_sample(directed_vals[i]);
    end
    drain();
    set_trim(8'd255);
    offer_sample(16'sh1234);
    offer_sample(16'shFFB3);
    drain();
    apb_write(UNMAPPED_ADDR, 32'h0000_0040);
    offer_sample(16'sh0ABC);
    drain();
    set_trim(8'd64);
    offer_sample(16'sh8001);
    offer_sample(16'sh7FFE);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin
          src_gap_pct   = 0;
          snk_stall_pct = 0;
        end
        1: begin
          src_gap_pct   = 57;
          snk_stall_pct = 0;
        end
        2: begin
          src_gap_pct   = 0;
          snk_stall_pct = 57;
        end
        default: begin
          src_gap_pct   = 15;
          snk_stall_pct = 15;
        end
      endcase
      trim = (p == RAND_PHASE) ? TRIM_W'($urandom()) : trim_plan[p];
      set_trim(trim);
      if (p == PRESS_PHASE) begin
        @(posedge clk_i);
        ->hold_kick;
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        last_sample = pick_sample(last_sample);
        offer_sample(last_sample);
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("Sent %0d samples across %0d trim settings, with idle, stall and back-pressure.",
             items_sent, trims_written);
    $display("Checked %0d results, %0d of them passed through.",
             results_checked, passthru_seen);
    if (fail_count == 0) begin
      $display("trimmed_mean_window_filter_tb: PASS");
    end else begin
      $display("trimmed_mean_window_filter_tb: FAIL");
    end
    $finish;
  end

endmodule
